// File: hw/rtl/bflk_pkg.sv
// Shared types, sizes and helpers for the bidirectional flow lookup block.
// No dependencies; the cell and the top level refer to it by scoped names.

package bflk_pkg;

  // Table size and the derived widths
  localparam int FLOW_ENTRIES = 64;
  localparam int CELL_SLOTS   = 8;
  localparam int SLOT_W       = 3;
  localparam int NUM_CELLS    = (FLOW_ENTRIES + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam int CELL_W       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int GIDX_W       = CELL_W + SLOT_W;
  localparam int CMP_W        = GIDX_W + 1;
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
  localparam int OUT_IDX_W    = 6;

  // One stored flow, endpoints as first seen
  typedef struct packed {
    logic [31:0] addr1;
    logic [15:0] port1;
    logic [31:0] addr2;
    logic [15:0] port2;
  } flow_t;

  // Search request travelling down the chain
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [GIDX_W-1:0] gidx;
  } tok_t;

  // Insertion control broadcast to the cells
  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] bank;
    logic [SLOT_W-1:0] slot;
  } wr_t;

  // Low bits of an entry index, zero-extended if the index is narrower
  function automatic logic [OUT_IDX_W-1:0] to_flow_index(input logic [GIDX_W-1:0] g);
    logic [GIDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, g};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/bidirectional_flow_lookup_insert.sv
// Top level of the bidirectional flow lookup with insertion on a miss.
// Chains bflk_cell instances; types and sizes come from bflk_pkg.
//
//   channel | direction | ports                                           | handshake
//   in      | input     | in_src_addr in_src_port in_dst_addr in_dst_port | in_valid / in_stall
//   out     | output    | out_flow_index out_is_new out_overflow          | out_valid / out_stall
//
// A request is captured, then passes each cell of the chain in turn, each cell
// comparing a bank of eight entries; the search outcome is then collected and
// the result and any insertion are committed.
// One request is in flight at a time.
// Reset (rst_n low, synchronous) empties the table by clearing the fill count.
// in_stall is high from acceptance until the commit step; a result waiting on
// out_stall holds the commit step and so also the acceptance of the next request.

module bidirectional_flow_lookup_insert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_src_addr,
  input  logic [15:0] in_src_port,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_dst_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_flow_index,
  output logic        out_is_new,
  output logic        out_overflow
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                          state_r;
  state_t                          state_nxt;
  bflk_pkg::flow_t                 q_r;
  logic                            start_r;
  logic [bflk_pkg::CNT_W-1:0]      used_r;
  logic                            hit_found_r;
  logic [bflk_pkg::GIDX_W-1:0]     hit_gidx_r;
  logic                            out_valid_r;
  logic [5:0]                      out_flow_index_r;
  logic                            out_is_new_r;
  logic                            out_overflow_r;

  logic                            in_accept;
  logic                            commit;
  logic                            full;
  logic [bflk_pkg::CMP_W-1:0]      cnt_ext;
  bflk_pkg::wr_t                   wr;
  bflk_pkg::tok_t                  tok_c [bflk_pkg::NUM_CELLS+1];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign full      = (used_r == bflk_pkg::CNT_W'(bflk_pkg::FLOW_ENTRIES));
  assign cnt_ext   = bflk_pkg::CMP_W'(used_r);

  // Insert at the fill level on a miss with room left
  always_comb begin
    wr.en   = commit && !hit_found_r && !full;
    wr.bank = cnt_ext[bflk_pkg::GIDX_W-1:bflk_pkg::SLOT_W];
    wr.slot = cnt_ext[bflk_pkg::SLOT_W-1:0];
  end

  // Launch the search at the head of the chain
  always_comb begin
    tok_c[0].valid = start_r;
    tok_c[0].found = 1'b0;
    tok_c[0].gidx  = '0;
  end

  for (genvar k = 0; k < bflk_pkg::NUM_CELLS; k++) begin : g_cell
    bflk_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_id    (bflk_pkg::CELL_W'(k)),
      .used_count (used_r),
      .query      (q_r),
      .wr         (wr),
      .tok_in     (tok_c[k]),
      .tok_out    (tok_c[k+1])
    );
  end

  // Sequence one request: capture, search, commit
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tok_c[bflk_pkg::NUM_CELLS].valid) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_accept;
      if (wr.en) begin
        used_r <= used_r + bflk_pkg::CNT_W'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request, the search outcome and the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_r.addr1 <= in_src_addr;
      q_r.port1 <= in_src_port;
      q_r.addr2 <= in_dst_addr;
      q_r.port2 <= in_dst_port;
    end
    if ((state_r == ST_SEARCH) && tok_c[bflk_pkg::NUM_CELLS].valid) begin
      hit_found_r <= tok_c[bflk_pkg::NUM_CELLS].found;
      hit_gidx_r  <= tok_c[bflk_pkg::NUM_CELLS].gidx;
    end
    if (commit) begin
      if (hit_found_r) begin
        out_flow_index_r <= bflk_pkg::to_flow_index(hit_gidx_r);
        out_is_new_r     <= 1'b0;
        out_overflow_r   <= 1'b0;
      end else if (full) begin
        out_flow_index_r <= '0;
        out_is_new_r     <= 1'b0;
        out_overflow_r   <= 1'b1;
      end else begin
        out_flow_index_r <= bflk_pkg::to_flow_index(cnt_ext[bflk_pkg::GIDX_W-1:0]);
        out_is_new_r     <= 1'b1;
        out_overflow_r   <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_flow_index = out_flow_index_r;
  assign out_is_new     = out_is_new_r;
  assign out_overflow   = out_overflow_r;

`ifndef SYNTHESIS
  // The fill level never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= bflk_pkg::CNT_W'(bflk_pkg::FLOW_ENTRIES))
    else $error("flow table fill level beyond table size");

  // A search only leaves the chain while the sequencer waits for it
  a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_c[bflk_pkg::NUM_CELLS].valid |-> (state_r == ST_SEARCH))
    else $error("search request left the chain outside the search step");

  // An accepted request starts exactly one search
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (start_r && (state_r == ST_SEARCH)))
    else $error("accepted request did not launch a search");

  // A result is never both new and an overflow
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_new_r && out_overflow_r))
    else $error("result flagged both new and overflow");
`endif

endmodule

// File: hw/rtl/bflk_cell.sv
// One cell of the flow table chain: holds a bank of entries, compares them
// against the broadcast request and passes the search state on. Uses bflk_pkg.

module bflk_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bflk_pkg::CELL_W-1:0]    cell_id,
  input  logic [bflk_pkg::CNT_W-1:0]     used_count,
  input  bflk_pkg::flow_t                query,
  input  bflk_pkg::wr_t                  wr,
  input  bflk_pkg::tok_t                 tok_in,
  output bflk_pkg::tok_t                 tok_out
);

  bflk_pkg::flow_t                       ent_r [bflk_pkg::CELL_SLOTS];
  logic [bflk_pkg::CELL_SLOTS-1:0]       slot_match;
  logic                                  hit_any;
  logic [bflk_pkg::SLOT_W-1:0]           hit_slot;
  logic [bflk_pkg::CMP_W-1:0]            cnt_ext;
  bflk_pkg::tok_t                        tok_r;
  bflk_pkg::tok_t                        tok_nxt;

  assign cnt_ext = bflk_pkg::CMP_W'(used_count);

  // Store and compare each slot
  for (genvar s = 0; s < bflk_pkg::CELL_SLOTS; s++) begin : g_slot
    logic [bflk_pkg::CMP_W-1:0] gidx_ext;
    logic                       fwd;
    logic                       rev;

    assign gidx_ext = {1'b0, cell_id, bflk_pkg::SLOT_W'(s)};
    assign fwd = (ent_r[s].addr1 == query.addr1) && (ent_r[s].port1 == query.port1) &&
                 (ent_r[s].addr2 == query.addr2) && (ent_r[s].port2 == query.port2);
    assign rev = (ent_r[s].addr2 == query.addr1) && (ent_r[s].port2 == query.port1) &&
                 (ent_r[s].addr1 == query.addr2) && (ent_r[s].port1 == query.port2);
    // only slots below the fill level take part
    assign slot_match[s] = (gidx_ext < cnt_ext) && (fwd || rev);

    always_ff @(posedge clk) begin
      if (wr.en && (wr.bank == cell_id) && (wr.slot == bflk_pkg::SLOT_W'(s))) begin
        ent_r[s] <= query;
      end
    end
  end

  // Pick the lowest matching slot
  always_comb begin
    hit_any  = 1'b0;
    hit_slot = '0;
    for (int s = bflk_pkg::CELL_SLOTS - 1; s >= 0; s--) begin
      if (slot_match[s]) begin
        hit_any  = 1'b1;
        hit_slot = bflk_pkg::SLOT_W'(s);
      end
    end
  end

  // Keep an earlier hit, otherwise take this bank's
  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.found = tok_in.found | hit_any;
    tok_nxt.gidx  = tok_in.found ? tok_in.gidx : {cell_id, hit_slot};
  end

  // Advance the request to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: tb/tb_bidirectional_flow_lookup_insert.sv
// Self-checking bench for the bidirectional flow lookup with insertion on a miss.
// Drives request tuples, predicts index, new and overflow flags, checks every result.
// Depends on bflk_pkg and bidirectional_flow_lookup_insert.

module tb_bidirectional_flow_lookup_insert;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int MAX_WAIT        = 12;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 400000;

  // Expected outcome of one lookup
  typedef struct packed {
    logic [bflk_pkg::OUT_IDX_W-1:0] flow_index;
    logic                           is_new;
    logic                           overflow;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_src_addr = '0;
  logic [15:0] in_src_port = '0;
  logic [31:0] in_dst_addr = '0;
  logic [15:0] in_dst_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [5:0]  out_flow_index;
  logic        out_is_new;
  logic        out_overflow;

  // Request tuples waiting to be sent, and the tuples the generator has invented
  bflk_pkg::flow_t pending_pkts[$];
  bflk_pkg::flow_t seen_tuples[$];
  flow_result_t    expected_results[$];

  // Predictor state: stored flows in insertion order and fill count
  bflk_pkg::flow_t known_flows[bflk_pkg::FLOW_ENTRIES];
  int unsigned     flows_used = 0;

  int  requests_sent = 0;
  int  requests_taken = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  hit_count = 0;
  int  new_count = 0;
  int  overflow_count = 0;
  int  cycle_count = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  bflk_pkg::flow_t next_pkt;

  bidirectional_flow_lookup_insert dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_src_addr    (in_src_addr),
    .in_src_port    (in_src_port),
    .in_dst_addr    (in_dst_addr),
    .in_dst_port    (in_dst_port),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_flow_index (out_flow_index),
    .out_is_new     (out_is_new),
    .out_overflow   (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Search the stored flows in either direction; append on a miss if room remains
  function automatic flow_result_t lookup_or_insert(input bflk_pkg::flow_t pkt);
    flow_result_t    res;
    bflk_pkg::flow_t f;
    res = '0;
    for (int unsigned i = 0; i < flows_used; i++) begin
      f = known_flows[i];
      if ((f.addr1 == pkt.addr1 && f.port1 == pkt.port1 &&
           f.addr2 == pkt.addr2 && f.port2 == pkt.port2) ||
          (f.addr2 == pkt.addr1 && f.port2 == pkt.port1 &&
           f.addr1 == pkt.addr2 && f.port1 == pkt.port2)) begin
        res.flow_index = bflk_pkg::OUT_IDX_W'(i);
        hit_count++;
        return res;
      end
    end
    if (flows_used >= bflk_pkg::FLOW_ENTRIES) begin
      res.overflow = 1'b1;
      overflow_count++;
      return res;
    end
    known_flows[flows_used] = pkt;
    res.flow_index = bflk_pkg::OUT_IDX_W'(flows_used);
    res.is_new = 1'b1;
    flows_used++;
    new_count++;
    return res;
  endfunction

  task automatic queue_packet(input bflk_pkg::flow_t pkt, input bit remember);
    pending_pkts.push_back(pkt);
    if (remember) seen_tuples.push_back(pkt);
  endtask

  // Send requests: hold a stalled one, else wait out the gap and load the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_pkts.size() > 0) begin
      next_pkt = pending_pkts.pop_front();
      in_src_addr <= next_pkt.addr1;
      in_src_port <= next_pkt.port1;
      in_dst_addr <= next_pkt.addr2;
      in_dst_port <= next_pkt.port2;
      in_valid <= 1'b1;
      if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
      gap_left = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result side for a random number of cycles after each result
  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      hold_left = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end
    out_stall <= (hold_left > 0);
    if (hold_left > 0) hold_left--;
  end

  // Predict on every accepted request and check every accepted result
  always @(posedge clk) begin
    in_fire  <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(lookup_or_insert('{in_src_addr, in_src_port,
                                                    in_dst_addr, in_dst_port}));
      requests_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin : check_result
      flow_result_t exp_res;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result index=%0d new=%0b overflow=%0b", $time,
                 out_flow_index, out_is_new, out_overflow);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_flow_index !== exp_res.flow_index) begin
          $display("%0t: flow_index expected %0d actual %0d", $time,
                   exp_res.flow_index, out_flow_index);
          mismatches++;
        end
        if (out_is_new !== exp_res.is_new) begin
          $display("%0t: is_new expected %0b actual %0b", $time,
                   exp_res.is_new, out_is_new);
          mismatches++;
        end
        if (out_overflow !== exp_res.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   exp_res.overflow, out_overflow);
          mismatches++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d requests taken, %0d results awaited", $time,
               requests_taken, requests_sent, expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    bflk_pkg::flow_t pkt;
    bflk_pkg::flow_t base;
    int              pick;
    int              span;

    // Directed: empty table, symmetric and extreme tuples, both directions, near misses
    queue_packet('{32'h0, 16'h0, 32'h0, 16'h0}, 1'b1);
    queue_packet('{32'h0, 16'h0, 32'h0, 16'h0}, 1'b0);
    queue_packet('{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1);
    queue_packet('{32'h0102_0304, 16'd80, 32'h0506_0708, 16'd443}, 1'b1);
    queue_packet('{32'h0506_0708, 16'd443, 32'h0102_0304, 16'd80}, 1'b0);
    queue_packet('{32'h0102_0304, 16'd80, 32'h0506_0708, 16'd443}, 1'b0);
    queue_packet('{32'h0506_0708, 16'd80, 32'h0102_0304, 16'd443}, 1'b1);
    queue_packet('{32'h0102_0304, 16'd80, 32'h0506_0708, 16'd442}, 1'b1);
    queue_packet('{32'hFFFF_FFFF, 16'h0, 32'h0, 16'hFFFF}, 1'b1);
    queue_packet('{32'h0, 16'hFFFF, 32'hFFFF_FFFF, 16'h0}, 1'b0);
    queue_packet('{32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1);
    queue_packet('{32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0}, 1'b0);
    queue_packet('{32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 16'hAAAA}, 1'b1);
    queue_packet('{32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA, 16'h5555}, 1'b0);

    // Random: fresh flows fill the table, then repeats, reversals and near misses
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        pkt = '{$urandom, 16'($urandom), $urandom, 16'($urandom)};
        if ($urandom_range(0, 7) == 0) begin
          pkt.addr2 = pkt.addr1;
          pkt.port2 = pkt.port1;
        end
        queue_packet(pkt, 1'b1);
      end else begin
        // favour the early tuples, which are the ones that made it into the table
        span = seen_tuples.size();
        if ($urandom_range(0, 1) == 0 && span > bflk_pkg::FLOW_ENTRIES + 8)
          span = bflk_pkg::FLOW_ENTRIES + 8;
        base = seen_tuples[$urandom_range(0, span - 1)];
        if (pick < 60) begin
          queue_packet(base, 1'b0);
        end else if (pick < 88) begin
          queue_packet('{base.addr2, base.port2, base.addr1, base.port1}, 1'b0);
        end else begin
          case ($urandom_range(0, 3))
            0: pkt = '{base.addr2, base.port1, base.addr1, base.port2};
            1: pkt = '{base.addr1, base.port2, base.addr2, base.port1};
            2: begin
              pkt = base;
              pkt.port2 ^= 16'(1) << $urandom_range(0, 15);
            end
            default: begin
              pkt = base;
              pkt.addr1 ^= 32'(1) << $urandom_range(0, 31);
            end
          endcase
          queue_packet(pkt, 1'b1);
        end
      end
    end
    requests_sent = pending_pkts.size();

    // Reset, then let the driver and monitor run until everything has drained
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    while (requests_taken < requests_sent || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Covered %0d requests and %0d results: %0d new flows, %0d hits, %0d overflows.",
             requests_taken, results_seen, new_count, hit_count, overflow_count);
    $display("Table held %0d of %0d flows; %0d field mismatches.", flows_used,
             bflk_pkg::FLOW_ENTRIES, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bflk_pkg.sv
hw/rtl/bflk_cell.sv
hw/rtl/bidirectional_flow_lookup_insert.sv
tb/tb_bidirectional_flow_lookup_insert.sv
